>>> sv/fud_pkg.sv
// shared types, codes and character helpers for the form body decoder
`default_nettype none
package fud_pkg;

   localparam int FIFO_DEPTH_DEFAULT = 4;

   typedef enum logic [1:0] {
      MODE_NAME  = 2'd0,
      MODE_VALUE = 2'd1,
      MODE_HEX1  = 2'd2,
      MODE_HEX2  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_NAME    = 2'd0,
      KIND_VALUE   = 2'd1,
      KIND_DONE    = 2'd2,
      KIND_ABANDON = 2'd3
   } kind_type;

   localparam logic [7:0] CHAR_EQUALS  = 8'h3d;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_SEMI    = 8'h3b;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_PLUS    = 8'h2b;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] out_byte;
      logic       run_last;
   } result_type;

   // results produced by one input beat
   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } decode_type;

   function automatic logic is_alnum(input logic [7:0] c);
      return (c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]});
   endfunction

   // bit 4 set means not a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'h10;
      if (c inside {[8'h30:8'h39]}) begin
         v = {1'b0, c[3:0]};
      end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         v = {1'b0, c[3:0] + 4'd9};
      end
      return v;
   endfunction

endpackage
`default_nettype wire

>>> sv/fud_decode.sv
// scan mode state and per-beat decode into at most two results
`default_nettype none
module fud_decode
   import fud_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] data_byte,
   input  wire logic       body_end,
   output decode_type      decoded
);

   mode_type   mode_ff, mode_in;
   logic [3:0] nibble_ff, nibble_in;

   logic       emit0;
   result_type first;
   mode_type   mode_mid;
   logic [4:0] hex;
   result_type tail;

   always_comb begin
      hex      = hex_value(data_byte);
      emit0    = 1'b0;
      first    = '{kind: KIND_NAME, out_byte: 8'h00, run_last: 1'b0};
      mode_mid = mode_ff;
      nibble_in = nibble_ff;
      case (mode_ff)
         MODE_NAME: begin
            if (data_byte == CHAR_EQUALS) begin
               mode_mid = MODE_VALUE;
            end else if (is_alnum(data_byte)) begin
               emit0 = 1'b1;
               first.out_byte = data_byte;
            end
         end
         MODE_VALUE: begin
            if (data_byte == CHAR_SEMI || data_byte == CHAR_AMP) begin
               emit0 = 1'b1;
               first.kind = KIND_DONE;
               mode_mid = MODE_NAME;
            end else if (data_byte == CHAR_PERCENT) begin
               mode_mid = MODE_HEX1;
            end else begin
               emit0 = 1'b1;
               first.kind = KIND_VALUE;
               first.out_byte = (data_byte == CHAR_PLUS) ? CHAR_SPACE : data_byte;
            end
         end
         MODE_HEX1: begin
            if (!hex[4]) begin
               nibble_in = hex[3:0];
               mode_mid = MODE_HEX2;
            end else begin
               mode_mid = MODE_VALUE;
            end
         end
         default: begin
            if (!hex[4]) begin
               emit0 = 1'b1;
               first.kind = KIND_VALUE;
               first.out_byte = {nibble_ff, hex[3:0]};
            end
            mode_mid = MODE_VALUE;
         end
      endcase

      tail = '{kind: (mode_mid == MODE_NAME) ? KIND_ABANDON : KIND_DONE,
               out_byte: 8'h00, run_last: 1'b1};

      decoded = '{count: 2'd0, r0: first, r1: tail};
      if (emit0 && body_end) begin
         decoded.count = 2'd2;
      end else if (emit0) begin
         decoded.count = 2'd1;
         decoded.r0.run_last = 1'b1;
      end else if (body_end) begin
         decoded.count = 2'd1;
         decoded.r0 = tail;
      end

      mode_in = mode_mid;
      if (body_end) begin
         mode_in   = MODE_NAME;
         nibble_in = 4'h0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NAME;
         nibble_ff <= 4'h0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         nibble_ff <= nibble_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/form_urlencoded_decoder_top.sv
// top level of the form body decoder: byte decode and result queue
//
// req channel: one body byte per beat (req_data_byte) with req_body_end
// marking the last byte of a body. rsp channel: one result per beat with
// rsp_kind (name byte, value byte, pair complete, pair abandoned),
// rsp_out_byte and rsp_run_last flagging the final result of a byte.
// both channels move a beat when valid is high and stall is low.
// a byte is decoded in the cycle it is accepted and its zero, one or two
// results are written into a small queue whose head is offered on rsp.
// throughput is one byte per cycle while rsp is not stalled and each byte
// yields at most one result; a byte with two results (a decoded byte plus
// end of body) takes two rsp beats, as the queue has a single read port.
// req_stall rises when the queue has fewer than two free entries, so a
// stalled receiver backs up into the sender once FIFO_DEPTH - 1 or more
// results are waiting.
// reset (synchronous, active high) returns the scan mode to name
// scanning, clears the pending escape nibble and empties the queue.
`default_nettype none
module form_urlencoded_decoder_top
   import fud_pkg::*;
#(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_body_end,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_kind,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_run_last
);

   localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CW = $clog2(FIFO_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(FIFO_DEPTH);
   localparam logic [CW-1:0] ROOM_MAX = CW'(FIFO_DEPTH - 2);
   localparam logic [PW-1:0] LAST_PTR = PW'(FIFO_DEPTH - 1);

   logic       req_accept;
   logic       rsp_accept;
   decode_type decoded;

   // queue storage and pointers
   result_type       queue_ff [FIFO_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [PW-1:0]    wr_next;
   logic [1:0]       push_n;
   result_type       head;

   // keep room for the worst case of two results per byte
   assign req_stall  = (count_ff > ROOM_MAX);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (count_ff != '0);
   assign rsp_accept = rsp_valid && !rsp_stall;

   fud_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .data_byte (req_data_byte),
      .body_end  (req_body_end),
      .decoded   (decoded)
   );

   always_comb begin
      push_n    = req_accept ? decoded.count : 2'd0;
      wr_next   = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      wr_ptr_in = wr_ptr_ff;
      if (push_n == 2'd1) begin
         wr_ptr_in = wr_next;
      end else if (push_n == 2'd2) begin
         wr_ptr_in = (wr_next == LAST_PTR) ? '0 : wr_next + PW'(1);
      end
      rd_ptr_in = rd_ptr_ff;
      if (rsp_accept) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      count_in = count_ff + CW'(push_n) - CW'(rsp_accept);
   end

   // payload entries, no reset needed
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= decoded.r0;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_next] <= decoded.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // head of queue drives the rsp payload
   assign head         = queue_ff[rd_ptr_ff];
   assign rsp_kind     = head.kind;
   assign rsp_out_byte = head.out_byte;
   assign rsp_run_last = head.run_last;

   // queue never overfills
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("result queue over capacity");

   // pop with no push drops the fill by exactly one
   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && push_n == 2'd0) |=> count_ff == $past(count_ff) - CW'(1))
      else $error("queue fill wrong after pop");

   // a beat with two results moves the write pointer by two (checked unless the second entry lands in the last slot)
   a_push_two: assert property (@(posedge clock) disable iff (reset)
      (push_n == 2'd2 && wr_next != LAST_PTR) |=>
         wr_ptr_ff == $past(wr_next) + PW'(1))
      else $error("write pointer wrong after double push");

endmodule
`default_nettype wire
